/* rtl/rgbpb_pkg.sv */
// Shared types, constants and an arithmetic helper for the RGBA pixel blender.
`default_nettype none

package rgbpb_pkg;

	localparam int CH_W     = 8;
	localparam int MODE_W   = 3;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;
	localparam int PROD_W   = 2 * CH_W;

	typedef logic [CH_W-1:0]   chan_t;
	typedef logic [MODE_W-1:0] mode_t;
	typedef logic [PROD_W-1:0] prod_t;

	typedef enum logic [MODE_W-1:0] {
		BM_NONE        = 3'd0,
		BM_ALPHA       = 3'd1,
		BM_ADDITIVE    = 3'd2,
		BM_MULTIPLY    = 3'd3,
		BM_SUBTRACTIVE = 3'd4,
		BM_SCREEN      = 3'd5,
		BM_OVERLAY     = 3'd6
	} blend_mode_t;

	localparam logic REG_BLEND_MODE = 1'b0;

	localparam mode_t MODE_RESET = BM_NONE;

	// Exact floor(x / 255) for every x below 65280, by multiplying with the reciprocal.
	function automatic chan_t div255(input prod_t x);
		logic [24:0] p;
		p = ({9'd0, x} + 25'd1) * 25'd257;
		return p[23:16];
	endfunction

endpackage

`default_nettype wire

/* rtl/rgbpb_apb_regs.sv */
// APB register block holding the blend mode register.
`default_nettype none

module rgbpb_apb_regs
	import rgbpb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output mode_t                  blend_mode
);

	mode_t mode_q;
	logic  wr_en;
	logic  hit_mode;

	assign pready   = 1'b1;
	assign hit_mode = (paddr[2] == REG_BLEND_MODE) && (paddr[1:0] == 2'b00);
	assign wr_en    = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (wr_en && hit_mode) begin
			mode_q <= pwdata[MODE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (hit_mode) begin
			prdata = {{(APB_DW-MODE_W){1'b0}}, mode_q};
		end
	end

	assign blend_mode = mode_q;

endmodule

`default_nettype wire

/* rtl/rgbpb_chan.sv */
// Blend arithmetic for one colour or alpha channel of a pixel.
`default_nettype none

module rgbpb_chan
	import rgbpb_pkg::*;
(
	input  wire mode_t mode,
	input  wire logic  alpha_lane,
	input  wire chan_t d,
	input  wire chan_t s,
	input  wire chan_t a,
	output chan_t      r
);

	prod_t       p_sa;
	prod_t       p_da;
	prod_t       p_mul;
	prod_t       p_scr;
	prod_t       alpha_sum;
	prod_t       div_in;
	logic        inv;
	chan_t       quo;
	logic [8:0]  add_sum;
	chan_t       add_sat;
	chan_t       sub_clamp;

	always_comb begin
		p_sa      = alpha_lane ? ({a, 8'd0} - {8'd0, a}) : (s * a);
		p_da      = d * chan_t'(~a);
		p_mul     = d * s;
		p_scr     = chan_t'(~d) * chan_t'(~s);
		alpha_sum = p_sa + p_da;
		add_sum   = {1'b0, d} + {1'b0, s};
		add_sat   = add_sum[8] ? 8'hFF : add_sum[7:0];
		sub_clamp = (d > s) ? (d - s) : 8'd0;
	end

	always_comb begin
		div_in = p_mul;
		inv    = 1'b0;
		case (mode)
			BM_ALPHA: begin
				div_in = alpha_sum;
			end
			BM_SCREEN: begin
				div_in = p_scr;
				inv    = 1'b1;
			end
			BM_OVERLAY: begin
				if (d[7]) begin
					div_in = {p_scr[14:0], 1'b0} + 16'd254;
					inv    = 1'b1;
				end else begin
					div_in = {p_mul[14:0], 1'b0};
				end
			end
			default: begin
				div_in = p_mul;
				inv    = 1'b0;
			end
		endcase
	end

	assign quo = div255(div_in) ^ {CH_W{inv}};

	always_comb begin
		case (mode)
			BM_ALPHA, BM_MULTIPLY, BM_SCREEN, BM_OVERLAY: r = quo;
			BM_ADDITIVE:    r = add_sat;
			BM_SUBTRACTIVE: r = sub_clamp;
			default:        r = s;
		endcase
	end

endmodule

`default_nettype wire

/* rtl/rgba_pixel_blend.sv */
// Top level of the RGBA8 pixel blender: input stage, four channel units and result stage.
//
// Channel   Direction  Handshake               Payload
// in        input      in_valid / in_stall     dst_red..dst_alpha, src_red..src_alpha
// out       output     out_valid / out_stall   out_red, out_green, out_blue, out_alpha
// config    input      APB psel/penable/pready blend_mode at byte address 0
//
// Each pixel passes through the input register and then the result register,
// and one pixel can be transferred in every cycle unless in_stall is raised.
// The input register and result register bound a single pass of channel arithmetic.
// Reset clears both valid flags and sets the mode to none. A stalled result holds in
// the result register while the input register still takes one more pixel.
`default_nettype none

module rgba_pixel_blend
	import rgbpb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire chan_t             dst_red,
	input  wire chan_t             dst_green,
	input  wire chan_t             dst_blue,
	input  wire chan_t             dst_alpha,
	input  wire chan_t             src_red,
	input  wire chan_t             src_green,
	input  wire chan_t             src_blue,
	input  wire chan_t             src_alpha,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output chan_t                  out_red,
	output chan_t                  out_green,
	output chan_t                  out_blue,
	output chan_t                  out_alpha
);

	mode_t mode;
	logic  v_s1;
	logic  v_s2;
	logic  adv_s2;
	logic  mv_s1;
	logic  ld_s1;
	chan_t dst_s1 [4];
	chan_t src_s1 [4];
	chan_t res    [4];
	chan_t res_s2 [4];

	rgbpb_apb_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.blend_mode (mode)
	);

	assign adv_s2   = !v_s2 || !out_stall;
	assign mv_s1    = v_s1 && adv_s2;
	assign in_stall = v_s1 && !adv_s2;
	assign ld_s1    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ld_s1 || (v_s1 && !adv_s2);
			v_s2 <= mv_s1 || (v_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			dst_s1[0] <= dst_red;
			dst_s1[1] <= dst_green;
			dst_s1[2] <= dst_blue;
			dst_s1[3] <= dst_alpha;
			src_s1[0] <= src_red;
			src_s1[1] <= src_green;
			src_s1[2] <= src_blue;
			src_s1[3] <= src_alpha;
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_chan
		rgbpb_chan u_chan (
			.mode       (mode),
			.alpha_lane (i == 3),
			.d          (dst_s1[i]),
			.s          (src_s1[i]),
			.a          (src_s1[3]),
			.r          (res[i])
		);
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid = v_s2;
	assign out_red   = res_s2[0];
	assign out_green = res_s2[1];
	assign out_blue  = res_s2[2];
	assign out_alpha = res_s2[3];

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ld_s1 |=> v_s1)
		else $error("Accepted input transfer did not reach the input stage.");

	a_move_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		mv_s1 |=> v_s2)
		else $error("Pixel leaving the input stage did not reach the result stage.");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && out_stall))
		else $error("Input stalled while the pipeline had room.");

	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && out_stall) |=> (v_s2 && $stable(out_red) && $stable(out_alpha)))
		else $error("Stalled result was lost or changed.");

	a_none_passes_src: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_s1 && mode == BM_NONE) |=> (out_red == $past(src_s1[0])
			&& out_alpha == $past(src_s1[3])))
		else $error("Mode none did not pass the source pixel.");

endmodule

`default_nettype wire
